// File: src/assert_macros.svh
// assertion macros shared by the heap core
// relies on signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("%m: check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("%m: check failed");

`endif

// File: src/imh_pkg.sv
// shared constants, payload structs and control types of the indexed min-heap core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package imh_pkg;

   localparam int NUM_ENTRIES = 1024;
   localparam int KEY_W       = 24;
   localparam int ID_W        = 10;
   localparam int ACT_W       = 11;
   localparam int REQ_W       = 2;

   localparam logic [KEY_W-1:0] KEY_INF      = '1;
   localparam logic [ACT_W-1:0] ACTIVE_RESET = 11'd1024;

   typedef enum logic [REQ_W-1:0] {
      OP_INIT    = 2'd0,
      OP_SET_KEY = 2'd1,
      OP_POP     = 2'd2,
      OP_PEEK    = 2'd3
   } op_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [ID_W-1:0]  entry_id;
      logic [KEY_W-1:0] new_key;
   } req_item_type;

   typedef struct packed {
      logic [ID_W-1:0]  top_id;
      logic [KEY_W-1:0] top_key;
      logic             top_is_infinite;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SK_LOOK,
      ST_UP_CMP,
      ST_DN_PICK,
      ST_DN_MOVE,
      ST_PLACE,
      ST_DONE
   } state_type;

   // source of the slot written in a cycle
   typedef enum logic [2:0] {
      W_NONE,
      W_INIT,
      W_CUR,
      W_UP,
      W_DN
   } wsel_type;

   // operand pair of the shared key comparator
   typedef enum logic [1:0] {
      CMP_UP,
      CMP_KIDS,
      CMP_MOVE
   } cmp_sel_type;

   // read address of the slot memories
   typedef enum logic [1:0] {
      RA_ROOT,
      RA_LOOK,
      RA_UP,
      RA_KIDS
   } rsel_type;

   typedef struct packed {
      logic        accept;
      logic        init_step;
      logic        look;
      logic        up_move;
      logic        dn_pick;
      logic        dn_move;
      logic        finish;
      wsel_type    wsel;
      cmp_sel_type cmp_sel;
      rsel_type    rsel;
   } ctrl_type;

   typedef struct packed {
      op_type req_op;
      logic   heap_empty;
      logic   id_ok;
      logic   root_has_kid;
      logic   init_last;
      logic   slot_ok;
      logic   slot_zero;
      logic   par_zero;
      logic   kid_ok;
      logic   cmp_gt;
   } status_type;

endpackage

`default_nettype wire

// File: src/imh_ram.sv
// generic single-write, single-read memory with registered read data
// depends on imh_pkg for default sizes
`timescale 1ns / 1ps
`default_nettype none

module imh_ram #(
   parameter int WIDTH = imh_pkg::KEY_W,
   parameter int DEPTH = imh_pkg::NUM_ENTRIES
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/imh_key_cmp.sv
// shared key comparator with operand selection
// depends on imh_pkg for key width and operand select codes
`timescale 1ns / 1ps
`default_nettype none

module imh_key_cmp (
   input  imh_pkg::cmp_sel_type         sel,
   input  logic [imh_pkg::KEY_W-1:0]    rd_a_key,
   input  logic [imh_pkg::KEY_W-1:0]    rd_b_key,
   input  logic [imh_pkg::KEY_W-1:0]    cur_key,
   input  logic [imh_pkg::KEY_W-1:0]    ch_key,
   output logic                         gt
);

   logic [imh_pkg::KEY_W-1:0] op_a;
   logic [imh_pkg::KEY_W-1:0] op_b;

   always_comb begin
      case (sel)
         imh_pkg::CMP_UP: begin
            op_a = rd_a_key;
            op_b = cur_key;
         end
         imh_pkg::CMP_KIDS: begin
            op_a = rd_a_key;
            op_b = rd_b_key;
         end
         imh_pkg::CMP_MOVE: begin
            op_a = cur_key;
            op_b = ch_key;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign gt = op_a > op_b;

endmodule

`default_nettype wire

// File: src/imh_seq.sv
// sequencer of the heap core: init sweep, sift-up and sift-down steps
// depends on imh_pkg for state, status and control types
`timescale 1ns / 1ps
`default_nettype none

module imh_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  imh_pkg::status_type  status,
   output logic                 busy,
   output imh_pkg::ctrl_type    ctrl
);

   imh_pkg::state_type state_ff;
   imh_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         imh_pkg::ST_IDLE: begin
            if (start) begin
               case (status.req_op)
                  imh_pkg::OP_INIT: state_in = imh_pkg::ST_INIT;
                  imh_pkg::OP_SET_KEY: begin
                     state_in = status.id_ok ? imh_pkg::ST_SK_LOOK : imh_pkg::ST_DONE;
                  end
                  imh_pkg::OP_POP: begin
                     if (status.heap_empty) begin
                        state_in = imh_pkg::ST_DONE;
                     end else if (status.root_has_kid) begin
                        state_in = imh_pkg::ST_DN_PICK;
                     end else begin
                        state_in = imh_pkg::ST_PLACE;
                     end
                  end
                  default: state_in = imh_pkg::ST_DONE;
               endcase
            end
         end
         imh_pkg::ST_INIT: begin
            if (status.init_last) begin
               state_in = imh_pkg::ST_DONE;
            end
         end
         imh_pkg::ST_SK_LOOK: begin
            if (!status.slot_ok) begin
               state_in = imh_pkg::ST_DONE;
            end else if (status.slot_zero) begin
               state_in = imh_pkg::ST_PLACE;
            end else begin
               state_in = imh_pkg::ST_UP_CMP;
            end
         end
         imh_pkg::ST_UP_CMP: begin
            if (!status.cmp_gt) begin
               state_in = imh_pkg::ST_DONE;
            end else if (status.par_zero) begin
               state_in = imh_pkg::ST_PLACE;
            end
         end
         imh_pkg::ST_DN_PICK: state_in = imh_pkg::ST_DN_MOVE;
         imh_pkg::ST_DN_MOVE: begin
            if (!status.cmp_gt) begin
               state_in = imh_pkg::ST_DONE;
            end else if (status.kid_ok) begin
               state_in = imh_pkg::ST_DN_PICK;
            end else begin
               state_in = imh_pkg::ST_PLACE;
            end
         end
         imh_pkg::ST_PLACE: state_in = imh_pkg::ST_DONE;
         imh_pkg::ST_DONE: state_in = imh_pkg::ST_IDLE;
         default: state_in = imh_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      ctrl.wsel = imh_pkg::W_NONE;
      ctrl.cmp_sel = imh_pkg::CMP_UP;
      ctrl.rsel = imh_pkg::RA_ROOT;
      case (state_ff)
         imh_pkg::ST_IDLE: begin
            ctrl.accept = start;
            ctrl.rsel = imh_pkg::RA_ROOT;
         end
         imh_pkg::ST_INIT: begin
            ctrl.wsel = imh_pkg::W_INIT;
            ctrl.init_step = 1'b1;
         end
         imh_pkg::ST_SK_LOOK: begin
            ctrl.look = 1'b1;
            ctrl.rsel = imh_pkg::RA_LOOK;
         end
         imh_pkg::ST_UP_CMP: begin
            ctrl.cmp_sel = imh_pkg::CMP_UP;
            ctrl.rsel = imh_pkg::RA_UP;
            if (status.cmp_gt) begin
               ctrl.wsel = imh_pkg::W_UP;
               ctrl.up_move = 1'b1;
            end else begin
               ctrl.wsel = imh_pkg::W_CUR;
            end
         end
         imh_pkg::ST_DN_PICK: begin
            ctrl.cmp_sel = imh_pkg::CMP_KIDS;
            ctrl.dn_pick = 1'b1;
         end
         imh_pkg::ST_DN_MOVE: begin
            ctrl.cmp_sel = imh_pkg::CMP_MOVE;
            ctrl.rsel = imh_pkg::RA_KIDS;
            if (status.cmp_gt) begin
               ctrl.wsel = imh_pkg::W_DN;
               ctrl.dn_move = 1'b1;
            end else begin
               ctrl.wsel = imh_pkg::W_CUR;
            end
         end
         imh_pkg::ST_PLACE: ctrl.wsel = imh_pkg::W_CUR;
         imh_pkg::ST_DONE: ctrl.finish = 1'b1;
         default: ctrl.finish = 1'b0;
      endcase
   end

   assign busy = state_ff != imh_pkg::ST_IDLE;

endmodule

`default_nettype wire

// File: src/indexed_min_heap_decrease_key_core.sv
// top level of the indexed binary min-heap with decrease-key, pop and peek
// depends on imh_pkg, imh_ram, imh_key_cmp, imh_seq and assert_macros.svh
// from start to rsp_strobe: peek, pop on an empty heap and set-key of an id outside
//   the heap go straight to done; init sweeps the active entries; set-key finds the
//   slot and climbs a level per compare; pop picks and moves down a level per pair
// one request at a time, results cannot be stalled; busy stays high until the result
//   is written
// reset clears the heap to empty (peek and pop report id 0 with the infinite key) and
//   sets active_count to 1024; memories are not cleared, init lays them out
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module indexed_min_heap_decrease_key_core #(
   parameter int NUM_ENTRIES = imh_pkg::NUM_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   // request transfer
   input  logic                        start,
   output logic                        busy,
   input  imh_pkg::req_item_type       req_data,
   // result transfer, one cycle, cannot be held off
   output logic                        rsp_strobe,
   output imh_pkg::rsp_item_type       rsp_data,
   // active_count register
   input  logic                        csr_wr_en,
   input  logic [imh_pkg::ACT_W-1:0]   csr_wr_data
);

   localparam int KEY_W  = imh_pkg::KEY_W;
   localparam int ID_W   = imh_pkg::ID_W;
   localparam int ACT_W  = imh_pkg::ACT_W;
   localparam int SLOT_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
   localparam int CW     = (CNT_W > ACT_W) ? CNT_W : ACT_W;
   // wide enough for heap size, ids and child indexes up to 2*slot+2
   localparam int XW     = (CW > SLOT_W + 2) ? CW : SLOT_W + 2;
   localparam int WORD_W = KEY_W + SLOT_W;

   // control and status between sequencer and datapath
   imh_pkg::ctrl_type   ctrl;
   imh_pkg::status_type status;
   logic                cmp_gt;

   // registers
   logic [ACT_W-1:0]  active_count_ff, active_count_in;
   logic [CNT_W-1:0]  heap_size_ff, heap_size_in;
   logic [1:0]        op_ff, op_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [KEY_W-1:0]  cur_key_ff, cur_key_in;
   logic [SLOT_W-1:0] cur_ent_ff, cur_ent_in;
   logic [SLOT_W-1:0] par_ff, par_in;
   logic [SLOT_W-1:0] ch_slot_ff, ch_slot_in;
   logic [KEY_W-1:0]  ch_key_ff, ch_key_in;
   logic [SLOT_W-1:0] ch_ent_ff, ch_ent_in;
   logic [KEY_W-1:0]  rep_key_ff, rep_key_in;
   logic [SLOT_W-1:0] rep_ent_ff, rep_ent_in;
   logic [KEY_W-1:0]  top_key_ff, top_key_in;
   logic [SLOT_W-1:0] top_ent_ff, top_ent_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   imh_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   // memory ports
   logic [SLOT_W-1:0] eslot_rdata;
   logic [WORD_W-1:0] slot_a_rdata, slot_b_rdata;
   logic [KEY_W-1:0]  rd_a_key, rd_b_key;
   logic [SLOT_W-1:0] rd_a_ent, rd_b_ent;
   logic              wr_en;
   logic [KEY_W-1:0]  wr_key;
   logic [SLOT_W-1:0] wr_ent;

   // index arithmetic
   logic [XW-1:0]     heap_x, id_x, act_x, init_n_x;
   logic [XW-1:0]     lc_x, rc_x, kid_lc_x, rd_addr_a_x, rd_addr_b_x;
   logic [SLOT_W-1:0] look_par, up_par;
   logic              rc_ok, choose_r;

   assign rd_a_key = slot_a_rdata[WORD_W-1 -: KEY_W];
   assign rd_a_ent = slot_a_rdata[SLOT_W-1:0];
   assign rd_b_key = slot_b_rdata[WORD_W-1 -: KEY_W];
   assign rd_b_ent = slot_b_rdata[SLOT_W-1:0];

   assign heap_x = XW'(heap_size_ff);
   assign id_x   = XW'(req_data.entry_id);
   assign act_x  = XW'(active_count_ff);

   // init clamps the count to 1..NUM_ENTRIES
   assign init_n_x = (act_x == '0) ? XW'(1) :
                     ((act_x > XW'(NUM_ENTRIES)) ? XW'(NUM_ENTRIES) : act_x);

   // parent index, only used when the slot is not the root
   assign look_par = SLOT_W'((XW'(eslot_rdata) - XW'(1)) >> 1);
   assign up_par   = SLOT_W'((XW'(par_ff) - XW'(1)) >> 1);

   // children of the current slot and of the chosen child
   assign lc_x     = (XW'(cur_slot_ff) << 1) + XW'(1);
   assign rc_x     = lc_x + XW'(1);
   assign kid_lc_x = (XW'(ch_slot_ff) << 1) + XW'(1);
   assign rc_ok    = rc_x < heap_x;
   // left child wins ties, right only when strictly smaller
   assign choose_r = rc_ok && cmp_gt;

   always_comb begin
      case (ctrl.rsel)
         imh_pkg::RA_ROOT: rd_addr_a_x = XW'(1);
         imh_pkg::RA_LOOK: rd_addr_a_x = XW'(look_par);
         imh_pkg::RA_UP:   rd_addr_a_x = XW'(up_par);
         imh_pkg::RA_KIDS: rd_addr_a_x = kid_lc_x;
         default:          rd_addr_a_x = '0;
      endcase
   end

   // port b reads the slot after port a, the right sibling when port a reads a left child
   assign rd_addr_b_x = rd_addr_a_x + XW'(1);

   // every slot write lands on the current slot; the key and entry come from the step
   always_comb begin
      wr_en  = 1'b1;
      wr_key = cur_key_ff;
      wr_ent = cur_ent_ff;
      case (ctrl.wsel)
         imh_pkg::W_NONE: wr_en = 1'b0;
         imh_pkg::W_INIT: begin
            wr_key = imh_pkg::KEY_INF;
            wr_ent = cur_slot_ff;
         end
         imh_pkg::W_CUR: begin
            wr_key = cur_key_ff;
            wr_ent = cur_ent_ff;
         end
         imh_pkg::W_UP: begin
            wr_key = rd_a_key;
            wr_ent = rd_a_ent;
         end
         imh_pkg::W_DN: begin
            wr_key = ch_key_ff;
            wr_ent = ch_ent_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // slot memory, duplicated so both children are read in the same cycle
   imh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_ENTRIES)
   ) u_slot_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_slot_ff),
      .wr_data ({wr_key, wr_ent}),
      .rd_addr (rd_addr_a_x[SLOT_W-1:0]),
      .rd_data (slot_a_rdata)
   );

   imh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_ENTRIES)
   ) u_slot_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_slot_ff),
      .wr_data ({wr_key, wr_ent}),
      .rd_addr (rd_addr_b_x[SLOT_W-1:0]),
      .rd_data (slot_b_rdata)
   );

   // position map, entry id to slot
   imh_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_ENTRIES)
   ) u_entry_slot (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ent),
      .wr_data (cur_slot_ff),
      .rd_addr (id_x[SLOT_W-1:0]),
      .rd_data (eslot_rdata)
   );

   imh_key_cmp u_key_cmp (
      .sel      (ctrl.cmp_sel),
      .rd_a_key (rd_a_key),
      .rd_b_key (rd_b_key),
      .cur_key  (cur_key_ff),
      .ch_key   (ch_key_ff),
      .gt       (cmp_gt)
   );

   always_comb begin
      status.req_op       = imh_pkg::op_type'(req_data.req_type);
      status.heap_empty   = heap_size_ff == '0;
      status.id_ok        = id_x < heap_x;
      status.root_has_kid = heap_x > XW'(1);
      status.init_last    = (XW'(cur_slot_ff) + XW'(1)) == heap_x;
      status.slot_ok      = XW'(eslot_rdata) < heap_x;
      status.slot_zero    = eslot_rdata == '0;
      status.par_zero     = par_ff == '0;
      status.kid_ok       = kid_lc_x < heap_x;
      status.cmp_gt       = cmp_gt;
   end

   imh_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   // datapath next values
   always_comb begin
      active_count_in = active_count_ff;
      heap_size_in    = heap_size_ff;
      op_in           = op_ff;
      cur_slot_in     = cur_slot_ff;
      cur_key_in      = cur_key_ff;
      cur_ent_in      = cur_ent_ff;
      par_in          = par_ff;
      ch_slot_in      = ch_slot_ff;
      ch_key_in       = ch_key_ff;
      ch_ent_in       = ch_ent_ff;
      rep_key_in      = rep_key_ff;
      rep_ent_in      = rep_ent_ff;
      top_key_in      = top_key_ff;
      top_ent_in      = top_ent_ff;

      if (csr_wr_en) begin
         active_count_in = csr_wr_data;
      end

      // request transfer: latch operands, pop reports the top as it was
      if (ctrl.accept) begin
         op_in      = req_data.req_type;
         rep_key_in = top_key_ff;
         rep_ent_in = top_ent_ff;
         cur_slot_in = '0;
         case (status.req_op)
            imh_pkg::OP_INIT: heap_size_in = CNT_W'(init_n_x);
            imh_pkg::OP_SET_KEY: begin
               cur_key_in = req_data.new_key;
               cur_ent_in = id_x[SLOT_W-1:0];
            end
            imh_pkg::OP_POP: begin
               cur_key_in = imh_pkg::KEY_INF;
               cur_ent_in = top_ent_ff;
            end
            default: cur_slot_in = '0;
         endcase
      end

      if (ctrl.init_step) begin
         cur_slot_in = SLOT_W'(XW'(cur_slot_ff) + XW'(1));
      end

      // slot of the entry is known, first parent read goes out
      if (ctrl.look) begin
         cur_slot_in = eslot_rdata;
         par_in      = look_par;
      end

      // parent moved down into the hole, climb one level
      if (ctrl.up_move) begin
         cur_slot_in = par_ff;
         par_in      = up_par;
      end

      if (ctrl.dn_pick) begin
         ch_slot_in = choose_r ? rc_x[SLOT_W-1:0] : lc_x[SLOT_W-1:0];
         ch_key_in  = choose_r ? rd_b_key : rd_a_key;
         ch_ent_in  = choose_r ? rd_b_ent : rd_a_ent;
      end

      // child moved up into the hole, descend one level
      if (ctrl.dn_move) begin
         cur_slot_in = ch_slot_ff;
      end

      // mirror of slot 0
      if (wr_en && (cur_slot_ff == '0)) begin
         top_key_in = wr_key;
         top_ent_in = wr_ent;
      end
   end

   // result register
   always_comb begin
      rsp_strobe_in = ctrl.finish;
      rsp_data_in   = rsp_data_ff;
      if (ctrl.finish) begin
         if (op_ff == imh_pkg::OP_POP) begin
            rsp_data_in.top_id  = ID_W'(rep_ent_ff);
            rsp_data_in.top_key = rep_key_ff;
         end else begin
            rsp_data_in.top_id  = ID_W'(top_ent_ff);
            rsp_data_in.top_key = top_key_ff;
         end
         rsp_data_in.top_is_infinite = rsp_data_in.top_key == imh_pkg::KEY_INF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= imh_pkg::ACTIVE_RESET;
         heap_size_ff    <= '0;
         top_key_ff      <= imh_pkg::KEY_INF;
         top_ent_ff      <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         active_count_ff <= active_count_in;
         heap_size_ff    <= heap_size_in;
         top_key_ff      <= top_key_in;
         top_ent_ff      <= top_ent_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cur_slot_ff <= cur_slot_in;
      cur_key_ff  <= cur_key_in;
      cur_ent_ff  <= cur_ent_in;
      par_ff      <= par_in;
      ch_slot_ff  <= ch_slot_in;
      ch_key_ff   <= ch_key_in;
      ch_ent_ff   <= ch_ent_in;
      rep_key_ff  <= rep_key_in;
      rep_ent_ff  <= rep_ent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // init always leaves a non-empty heap
   `ASSERT_NEXT(a_init_sets_size, ctrl.accept && (status.req_op == imh_pkg::OP_INIT), heap_size_ff != '0)
   // after the init sweep entry 0 sits at the top with the infinite key
   `ASSERT_IMPL(a_init_top_inf, ctrl.finish && (op_ff == imh_pkg::OP_INIT), (top_key_ff == imh_pkg::KEY_INF) && (top_ent_ff == '0))
   // no slot is written while the heap is empty
   `ASSERT_IMPL(a_write_needs_heap, wr_en, heap_size_ff != '0)
   // sift-up always climbs toward the root
   `ASSERT_IMPL(a_up_toward_root, ctrl.up_move, par_ff < cur_slot_ff)
   // sift-down always moves to a deeper slot inside the heap
   `ASSERT_IMPL(a_down_in_heap, ctrl.dn_move, (ch_slot_ff > cur_slot_ff) && (XW'(ch_slot_ff) < heap_x))

endmodule

`default_nettype wire
